/* design/conv3zp_pkg.sv */
// Shared constants, types and register codes of the 3x3 zero-padded convolution stream unit.
package conv3zp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W     = 11;                          // width of a dimension register
    localparam int COL_W     = $clog2(MAX_WIDTH);           // column index / line memory address
    localparam int HGT_W     = $clog2(MAX_HEIGHT);          // last row index
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);      // input row, runs two rows past the frame
    localparam int PEND_W    = $clog2(MAX_WIDTH + 2);       // results left to drain
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;                          // signed Q8.8
    localparam int KROW_W    = 3 * COEF_W;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int RSUM_W    = PROD_W + 2;
    localparam int SUM_W     = 28;
    localparam int ODATA_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    // Coefficients 1.0, 0.0, -1.0 from left to right.
    localparam logic [KROW_W-1:0] KERNEL_RESET = 48'hFF00_0000_0100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_KTOP   = 3'd2,
        CFG_KMID   = 3'd3,
        CFG_KBOT   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    // Per-advance control carried from the counter stage to the window stage.
    typedef struct packed {
        logic       emit;     // this advance completes a result
        logic       fe;       // result is the last position of the frame
        logic [2:0] row_ok;   // kernel rows inside the frame, top in bit 0
        logic       col0_ok;  // left kernel column inside the frame
        logic       col2_ok;  // right kernel column inside the frame
    } t_tap_ctl;

endpackage

/* design/conv3x3_zero_pad_stream_unit.sv */
// 3x3 zero-padded image convolution over a raster pixel stream, line memory based.
//
// Usage:
//   Input stream (i_s_*): one beat per pixel in raster order, tuser = action.
//   A pixel beat (action 0) feeds the next frame position; after the last
//   pixel of the frame, flush beats (action 1) drain the remaining results,
//   the final one marked with o_m_tlast. Pixel beats while draining and
//   flush beats with nothing left are taken and dropped.
//   Output stream (o_m_*): the 28-bit two's complement convolution sum, upper bits zero.
//   Config channel (i_cfg_*): register index plus data, always ready; write
//   only while the unit is idle. A width or height write aborts the frame.
// Timing:
//   One beat per cycle sustained unless a stall holds the pipe. The first flush
//   beat of a one-row frame makes two line advances, with s_tready low during
//   the second. The result of frame position k is caused by pixel k+W+1 (or a
//   flush beat) and passes line memory read, window and multiply, row sums
//   and the output register before it shows on o_m_tvalid.
// Reset: counters and pipeline cleared, 1024x1024 frame, every kernel row
//   set to 1.0, 0.0, -1.0. The line memory is not cleared.
// Stall: the output register holds its beat; the pipe keeps taking beats
//   until a second finished result waits behind it, then s_tready drops.
module conv3x3_zero_pad_stream_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // pixel stream in
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [conv3zp_pkg::PIX_W-1:0]          i_s_tdata,   // [7:0] pixel
    input  logic [0:0]                             i_s_tuser,   // [0] action
    // result stream out
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [conv3zp_pkg::ODATA_W-1:0]        o_m_tdata,   // [27:0] conv_value, rest zero
    output logic                                   o_m_tlast,   // frame_end
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [conv3zp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [conv3zp_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int PW = conv3zp_pkg::PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [conv3zp_pkg::COL_W-1:0]  r_wm1;      // effective width minus one
    logic [conv3zp_pkg::HGT_W-1:0]  r_hm1;      // effective height minus one
    logic [conv3zp_pkg::KROW_W-1:0] r_krow [3];

    conv3zp_pkg::t_cfg_idx cfg_idx;
    logic                  cfg_wr;
    logic                  cfg_restart;

    // Clamp a written width to 1..MAX_WIDTH and keep it minus one.
    function automatic logic [conv3zp_pkg::COL_W-1:0] clamp_wm1(
        input logic [conv3zp_pkg::DIM_W-1:0] v
    );
        logic [conv3zp_pkg::DIM_W-1:0] m;
        if (v == '0) begin
            m = '0;
        end else if (v > conv3zp_pkg::DIM_W'(conv3zp_pkg::MAX_WIDTH)) begin
            m = conv3zp_pkg::DIM_W'(conv3zp_pkg::MAX_WIDTH - 1);
        end else begin
            m = v - conv3zp_pkg::DIM_W'(1);
        end
        return m[conv3zp_pkg::COL_W-1:0];
    endfunction

    function automatic logic [conv3zp_pkg::HGT_W-1:0] clamp_hm1(
        input logic [conv3zp_pkg::DIM_W-1:0] v
    );
        logic [conv3zp_pkg::DIM_W-1:0] m;
        if (v == '0) begin
            m = '0;
        end else if (v > conv3zp_pkg::DIM_W'(conv3zp_pkg::MAX_HEIGHT)) begin
            m = conv3zp_pkg::DIM_W'(conv3zp_pkg::MAX_HEIGHT - 1);
        end else begin
            m = v - conv3zp_pkg::DIM_W'(1);
        end
        return m[conv3zp_pkg::HGT_W-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_idx     = conv3zp_pkg::t_cfg_idx'(i_cfg_index);
    assign cfg_restart = cfg_wr && (cfg_idx == conv3zp_pkg::CFG_WIDTH ||
                                    cfg_idx == conv3zp_pkg::CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1    <= conv3zp_pkg::COL_W'(conv3zp_pkg::MAX_WIDTH - 1);
            r_hm1    <= conv3zp_pkg::HGT_W'(conv3zp_pkg::MAX_HEIGHT - 1);
            r_krow[0] <= conv3zp_pkg::KERNEL_RESET;
            r_krow[1] <= conv3zp_pkg::KERNEL_RESET;
            r_krow[2] <= conv3zp_pkg::KERNEL_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                conv3zp_pkg::CFG_WIDTH:  r_wm1 <= clamp_wm1(i_cfg_data[conv3zp_pkg::DIM_W-1:0]);
                conv3zp_pkg::CFG_HEIGHT: r_hm1 <= clamp_hm1(i_cfg_data[conv3zp_pkg::DIM_W-1:0]);
                conv3zp_pkg::CFG_KTOP:   r_krow[0] <= i_cfg_data[conv3zp_pkg::KROW_W-1:0];
                conv3zp_pkg::CFG_KMID:   r_krow[1] <= i_cfg_data[conv3zp_pkg::KROW_W-1:0];
                conv3zp_pkg::CFG_KBOT:   r_krow[2] <= i_cfg_data[conv3zp_pkg::KROW_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: position counters, beat decode, line memory read issue
    // ------------------------------------------------------------------
    logic [conv3zp_pkg::COL_W-1:0]  r_in_col, n_in_col;
    logic [conv3zp_pkg::ROW_W-1:0]  r_in_row, n_in_row;
    logic [conv3zp_pkg::PEND_W-1:0] r_pending, n_pending;
    logic                           r_dbl, n_dbl;   // second advance of a one-row flush

    logic                           en;             // pipeline advances this cycle
    logic                           take;
    logic                           is_flush;
    logic                           pend_nz;
    logic                           op_go;
    logic [PW-1:0]                  a_pix;
    logic                           a_shift;
    logic                           a_norm;
    logic [conv3zp_pkg::ROW_W-1:0]  a_r;
    logic [conv3zp_pkg::ROW_W-1:0]  hm1x;
    logic                           col_last;
    logic                           last_pix;
    logic [conv3zp_pkg::PEND_W-1:0] w_cnt;
    conv3zp_pkg::t_tap_ctl          a_ctl;

    // Pipeline registers declared early: en looks at the last stage.
    logic                           r_d_valid;
    logic                           r_out_valid;

    // Freeze only when a finished result sits behind a stalled output beat.
    assign en         = !(r_d_valid && r_out_valid && !i_m_tready);
    assign o_s_tready = en && !r_dbl;
    assign take       = i_s_tvalid && o_s_tready;
    assign is_flush   = (conv3zp_pkg::t_action'(i_s_tuser[0]) == conv3zp_pkg::ACT_FLUSH);
    assign pend_nz    = (r_pending != '0);
    assign op_go      = r_dbl ? en : (take && (is_flush ? pend_nz : !pend_nz));
    assign a_pix      = (r_dbl || is_flush) ? '0 : i_s_tdata;

    assign hm1x     = conv3zp_pkg::ROW_W'(r_hm1);
    assign col_last = (r_in_col == r_wm1);
    assign last_pix = (r_in_row == hm1x) && col_last;
    assign w_cnt    = conv3zp_pkg::PEND_W'(r_wm1) + conv3zp_pkg::PEND_W'(1);

    // Column 0 completes the right edge of two rows up; any other column
    // completes the position one row up and one column left.
    assign a_shift = (r_in_col == '0) && (r_in_row > conv3zp_pkg::ROW_W'(1));
    assign a_norm  = (r_in_col != '0) && (r_in_row != '0);
    assign a_r     = a_norm ? (r_in_row - conv3zp_pkg::ROW_W'(1))
                            : (r_in_row - conv3zp_pkg::ROW_W'(2));

    always_comb begin
        a_ctl.emit      = a_shift || a_norm;
        a_ctl.fe        = a_shift && (a_r == hm1x);
        a_ctl.row_ok[0] = (a_r != '0) && ((a_r - conv3zp_pkg::ROW_W'(1)) <= hm1x);
        a_ctl.row_ok[1] = (a_r <= hm1x);
        a_ctl.row_ok[2] = (a_r < hm1x);
        a_ctl.col0_ok   = a_norm ? (r_in_col > conv3zp_pkg::COL_W'(1)) : (r_wm1 != '0);
        a_ctl.col2_ok   = a_norm;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_pending = r_pending;
        n_dbl     = r_dbl;
        if (cfg_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_pending = '0;
            n_dbl     = 1'b0;
        end else if (op_go) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + conv3zp_pkg::ROW_W'(1);
            end else begin
                n_in_col = r_in_col + conv3zp_pkg::COL_W'(1);
            end
            if (r_dbl) begin
                n_dbl     = 1'b0;
                n_pending = r_pending - conv3zp_pkg::PEND_W'(1);
            end else if (is_flush) begin
                // a flush advance that completes nothing needs a second advance
                if (!a_ctl.emit) begin
                    n_dbl = 1'b1;
                end else begin
                    n_pending = r_pending - conv3zp_pkg::PEND_W'(1);
                end
            end else if (last_pix) begin
                n_pending = (r_hm1 != '0) ? (w_cnt + conv3zp_pkg::PEND_W'(1)) : w_cnt;
            end
            // last result of the frame: wait for a new frame at (0,0)
            if (a_ctl.fe) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_pending = '0;
                n_dbl     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_pending <= '0;
            r_dbl     <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_pending <= n_pending;
            r_dbl     <= n_dbl;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one entry per column, {row two up, row one up}
    // ------------------------------------------------------------------
    logic [2*PW-1:0]               r_line_mem [conv3zp_pkg::MAX_WIDTH];
    logic [2*PW-1:0]               r_rd_data;
    logic                          r_fwd;
    logic [2*PW-1:0]               r_fwd_data;

    logic                          r_b_valid;
    logic [conv3zp_pkg::COL_W-1:0] r_b_col;
    logic [PW-1:0]                 r_b_pix;
    conv3zp_pkg::t_tap_ctl         r_b_ctl;

    logic                          b_wr;
    logic [2*PW-1:0]               b_line;
    logic [PW-1:0]                 b_top;
    logic [PW-1:0]                 b_mid;
    logic [2*PW-1:0]               b_wdata;

    assign b_wr    = en && r_b_valid;
    assign b_line  = r_fwd ? r_fwd_data : r_rd_data;
    assign b_top   = b_line[2*PW-1:PW];
    assign b_mid   = b_line[PW-1:0];
    assign b_wdata = {b_mid, r_b_pix};

    // Read-first memory: a same-cycle write to the read entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (b_wr) begin
            r_line_mem[r_b_col] <= b_wdata;
        end
        if (op_go) begin
            r_rd_data  <= r_line_mem[r_in_col];
            r_fwd      <= b_wr && (r_b_col == r_in_col);
            r_fwd_data <= b_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= op_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_col <= r_in_col;
            r_b_pix <= a_pix;
            r_b_ctl <= a_ctl;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: window shift, edge masking, coefficient multiply
    // ------------------------------------------------------------------
    logic [PW-1:0] r_win [3][3];      // [kernel row][kernel column]
    logic [PW-1:0] n_win [3][3];
    logic [PW-1:0] b_tap [3][3];
    logic signed [conv3zp_pkg::PROD_W-1:0] b_prod [3][3];
    logic signed [conv3zp_pkg::COEF_W-1:0] b_coef [3][3];
    logic [PW-1:0] b_new [3];
    logic [2:0]    b_col_ok;

    assign b_new[0]    = b_top;
    assign b_new[1]    = b_mid;
    assign b_new[2]    = r_b_pix;
    assign b_col_ok[0] = r_b_ctl.col0_ok;
    assign b_col_ok[1] = 1'b1;
    assign b_col_ok[2] = r_b_ctl.col2_ok;

    // Both result kinds read the shifted window with kernel column = window column.
    always_comb begin
        for (int ky = 0; ky < 3; ky++) begin
            n_win[ky][0] = r_win[ky][1];
            n_win[ky][1] = r_win[ky][2];
            n_win[ky][2] = b_new[ky];
            for (int kx = 0; kx < 3; kx++) begin
                b_tap[ky][kx]  = (r_b_ctl.row_ok[ky] && b_col_ok[kx]) ? n_win[ky][kx] : '0;
                b_coef[ky][kx] = r_krow[ky][conv3zp_pkg::COEF_W*kx +: conv3zp_pkg::COEF_W];
                b_prod[ky][kx] = conv3zp_pkg::PROD_W'(signed'({1'b0, b_tap[ky][kx]}))
                               * conv3zp_pkg::PROD_W'(b_coef[ky][kx]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_wr) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // Stages C, D and output register
    // ------------------------------------------------------------------
    logic                                   r_c_valid;
    logic                                   r_c_fe;
    logic signed [conv3zp_pkg::PROD_W-1:0]  r_c_prod [3][3];
    logic                                   r_d_fe;
    logic signed [conv3zp_pkg::RSUM_W-1:0]  r_d_row [3];
    logic signed [conv3zp_pkg::RSUM_W-1:0]  c_row [3];
    logic signed [conv3zp_pkg::SUM_W-1:0]   d_sum;
    logic signed [conv3zp_pkg::SUM_W-1:0]   r_out_sum;
    logic                                   r_out_fe;

    always_comb begin
        for (int ky = 0; ky < 3; ky++) begin
            c_row[ky] = conv3zp_pkg::RSUM_W'(r_c_prod[ky][0])
                      + conv3zp_pkg::RSUM_W'(r_c_prod[ky][1])
                      + conv3zp_pkg::RSUM_W'(r_c_prod[ky][2]);
        end
    end

    assign d_sum = conv3zp_pkg::SUM_W'(r_d_row[0]) + conv3zp_pkg::SUM_W'(r_d_row[1])
                 + conv3zp_pkg::SUM_W'(r_d_row[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_c_valid <= r_b_valid && r_b_ctl.emit;
                r_d_valid <= r_c_valid;
            end
            if (en && r_d_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_prod <= b_prod;
            r_c_fe   <= r_b_ctl.fe;
            r_d_row  <= c_row;
            r_d_fe   <= r_c_fe;
        end
        if (en && r_d_valid) begin
            r_out_sum <= d_sum;
            r_out_fe  <= r_d_fe;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(conv3zp_pkg::ODATA_W - conv3zp_pkg::SUM_W){1'b0}}, r_out_sum};
    assign o_m_tlast  = r_out_fe;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The frame-end advance leaves the counters ready for a fresh frame.
    a_fe_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op_go && a_ctl.fe) |=> (r_in_row == '0 && r_in_col == '0 && r_pending == '0))
        else $error("frame end did not restart the position counters");

    // A drain advance that completes nothing is always followed by a second one.
    a_dbl_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op_go && !r_dbl && pend_nz && !a_ctl.emit && !cfg_restart) |=> r_dbl)
        else $error("empty drain advance without a second advance");

    // Draining only happens once the frame's last row has been entered.
    a_pend_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend_nz |-> (r_in_row != '0))
        else $error("results pending while still in the first row");

endmodule
